// ===== rtl/rrt_pkg.sv =====
// Package for the reassembly region tracker.
// Holds sizes, request codes, the result word type and the serial sequence compares.
// No dependencies.
`default_nettype none
package rrt_pkg;

  localparam int MAX_RANGES = 16;
  localparam int RIDX_W     = $clog2(MAX_RANGES);
  localparam int RCNT_W     = $clog2(MAX_RANGES + 1);
  localparam int SEQ_W      = 32;
  localparam int LEN_W      = 16;
  localparam int REQ_W      = 3;
  localparam int RCOUNT_W   = 5;
  localparam int ENTRY_W    = 2 * SEQ_W;

  localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_EXTRACT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INIT    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LEFT    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RIGHT   = 3'd4;

  typedef struct packed {
    logic [SEQ_W-1:0]    next_expected;
    logic [SEQ_W-1:0]    first_held;
    logic                extract_valid;
    logic [SEQ_W-1:0]    extracted_bytes;
    logic [SEQ_W-1:0]    edge_seq;
    logic [SEQ_W-1:0]    buffered_bytes;
    logic [SEQ_W-1:0]    free_bytes;
    logic [RCOUNT_W-1:0] range_count;
    logic                overflow;
  } rrt_res_t;

  // a precedes b in wrapping sequence space.
  function automatic logic sq_lt(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return d[SEQ_W-1];
  endfunction

  function automatic logic sq_le(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    return (a == b) || sq_lt(a, b);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rrt_in_if.sv =====
// Request channel of the reassembly region tracker.
// Depends on rrt_pkg.
`default_nettype none
interface rrt_in_if import rrt_pkg::*;;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [SEQ_W-1:0] seq_number;
  logic [LEN_W-1:0] byte_count;

  modport source (output valid, req_type, seq_number, byte_count, input ready);
  modport sink   (input valid, req_type, seq_number, byte_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/rrt_out_if.sv =====
// Result channel of the reassembly region tracker.
// Depends on rrt_pkg.
`default_nettype none
interface rrt_out_if import rrt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SEQ_W-1:0]    next_expected;
  logic [SEQ_W-1:0]    first_held;
  logic                extract_valid;
  logic [SEQ_W-1:0]    extracted_bytes;
  logic [SEQ_W-1:0]    edge_seq;
  logic [SEQ_W-1:0]    buffered_bytes;
  logic [SEQ_W-1:0]    free_bytes;
  logic [RCOUNT_W-1:0] range_count;
  logic                overflow;

  modport source (output valid, next_expected, first_held, extract_valid, extracted_bytes,
                  edge_seq, buffered_bytes, free_bytes, range_count, overflow,
                  input ready);
  modport sink   (input valid, next_expected, first_held, extract_valid, extracted_bytes,
                  edge_seq, buffered_bytes, free_bytes, range_count, overflow,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/rrt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module rrt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/rrt_ctrl.sv =====
// Sequencer of the reassembly region tracker: walks, merges and compacts the range table.
// Depends on rrt_pkg and rrt_ram (two banks, copied between on insert and whole extract).
`default_nettype none
module rrt_ctrl import rrt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [SEQ_W-1:0] cfg_wr_data,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire logic [REQ_W-1:0] req_type,
  input  wire logic [SEQ_W-1:0] req_seq,
  input  wire logic [LEN_W-1:0] req_len,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output rrt_res_t              res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_COPY  = 3'd3;
  localparam logic [2:0] ST_SHIFT = 3'd4;
  localparam logic [2:0] ST_EDGE  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]            state_r;
  logic [REQ_W-1:0]      req_r;
  logic [SEQ_W-1:0]      seq_r;
  logic [SEQ_W-1:0]      cap_r;
  logic [SEQ_W-1:0]      next_r;
  logic [SEQ_W-1:0]      bytes_r;
  logic [RCNT_W-1:0]     cnt_r;
  logic                  bank_r;
  logic [SEQ_W-1:0]      head_b_r;
  logic [SEQ_W-1:0]      head_e_r;
  logic [SEQ_W-1:0]      sb_r;
  logic [SEQ_W-1:0]      se_r;
  logic [MAX_RANGES-1:0] gone_r;
  logic [RCNT_W-1:0]     merged_r;
  logic [SEQ_W-1:0]      lost_r;
  logic [RIDX_W-1:0]     cur_r;
  logic [RCNT_W-1:0]     stop_r;
  logic [RCNT_W-1:0]     ck_r;
  logic [RCNT_W-1:0]     w_r;
  logic                  new_done_r;
  logic                  xvalid_r;
  logic [SEQ_W-1:0]      xbytes_r;
  logic [SEQ_W-1:0]      edge_r;
  logic                  ovf_r;

  logic                  accept;
  logic [RIDX_W-1:0]     raddr;
  logic [ENTRY_W-1:0]    rd0, rd1, rdata;
  logic [SEQ_W-1:0]      rb, re;
  logic                  we0, we1, wr_en, wr_active;
  logic [RIDX_W-1:0]     waddr;
  logic [ENTRY_W-1:0]    wdata;
  logic                  brk, mrg;
  logic                  x_hit, x_whole;
  logic                  copy_new;
  logic [RCNT_W-1:0]     cnt_m1, ck_p1;
  logic [SEQ_W-1:0]      next_adv;
  logic                  l_hit, r_hit;

  assign req_ready = (state_r == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign res_valid = (state_r == ST_DONE);

  assign rdata = bank_r ? rd1 : rd0;
  assign rb    = rdata[ENTRY_W-1:SEQ_W];
  assign re    = rdata[SEQ_W-1:0];

  assign cnt_m1 = cnt_r - 1'b1;
  assign ck_p1  = ck_r + 1'b1;

  // Walk decisions against the segment merged so far.
  assign brk = (re != sb_r) && (rb != se_r) && sq_lt(re, sb_r);
  assign mrg = !brk && !sq_lt(se_r, rb) && !sq_lt(re, sb_r);

  assign x_hit    = (cnt_r != '0) && !sq_le(req_seq, head_b_r);
  assign x_whole  = sq_le(head_e_r, req_seq);
  assign copy_new = !new_done_r && (ck_r == stop_r);

  assign l_hit = sq_le(rb, seq_r) && sq_lt(seq_r, re);
  assign r_hit = sq_lt(rb, seq_r) && sq_le(seq_r, re);

  always_comb begin
    raddr = '0;
    case (state_r)
      ST_IDLE: begin
        if (req_type == REQ_INSERT) begin
          raddr = cnt_m1[RIDX_W-1:0];
        end else if (req_type == REQ_EXTRACT) begin
          raddr = RIDX_W'(1);
        end
      end
      ST_WALK:  raddr = cur_r - 1'b1;
      ST_COPY:  raddr = copy_new ? ck_r[RIDX_W-1:0] : ck_p1[RIDX_W-1:0];
      ST_SHIFT: raddr = ck_p1[RIDX_W-1:0];
      ST_EDGE:  raddr = ck_p1[RIDX_W-1:0];
      default:  raddr = '0;
    endcase
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_active = 1'b0;
    waddr     = w_r[RIDX_W-1:0];
    wdata     = rdata;
    case (state_r)
      ST_IDLE: begin
        // Partial extract trims the first range in place.
        if (accept && req_type == REQ_EXTRACT && x_hit && !x_whole) begin
          wr_en     = 1'b1;
          wr_active = 1'b1;
          waddr     = '0;
          wdata     = {req_seq, head_e_r};
        end
      end
      ST_COPY: begin
        if (copy_new) begin
          wr_en = 1'b1;
          wdata = {sb_r, se_r};
        end else if (ck_r != cnt_r && !gone_r[ck_r[RIDX_W-1:0]]) begin
          wr_en = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (ck_r != cnt_r) begin
          wr_en = 1'b1;
          waddr = cnt_m1[RIDX_W-1:0] & '0 | (ck_r[RIDX_W-1:0] - 1'b1);
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign we0 = wr_en && ((bank_r == 1'b0) == wr_active);
  assign we1 = wr_en && ((bank_r == 1'b1) == wr_active);

  rrt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_bank0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0)
  );

  rrt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_bank1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1)
  );

  assign next_adv = (req_r == REQ_INSERT && !ovf_r && cnt_r != '0 && sq_le(head_b_r, next_r))
                    ? head_e_r : next_r;

  always_comb begin
    res.next_expected   = next_adv;
    res.first_held      = (cnt_r != '0 && sq_lt(head_b_r, next_adv)) ? head_b_r : next_adv;
    res.extract_valid   = xvalid_r;
    res.extracted_bytes = xbytes_r;
    res.edge_seq        = edge_r;
    res.buffered_bytes  = bytes_r;
    res.free_bytes      = (cap_r > bytes_r) ? (cap_r - bytes_r) : '0;
    res.range_count     = RCOUNT_W'(cnt_r);
    res.overflow        = ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cap_r   <= SEQ_W'(65535);
      next_r  <= '1;
      bytes_r <= '0;
      cnt_r   <= '0;
      bank_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            req_r    <= req_type;
            seq_r    <= req_seq;
            xvalid_r <= 1'b0;
            xbytes_r <= '0;
            edge_r   <= '0;
            ovf_r    <= 1'b0;
            sb_r     <= req_seq;
            se_r     <= req_seq + SEQ_W'(req_len);
            gone_r   <= '0;
            merged_r <= '0;
            lost_r   <= '0;
            cur_r    <= cnt_m1[RIDX_W-1:0];
            stop_r   <= '0;
            ck_r     <= '0;
            state_r  <= ST_DONE;
            case (req_type)
              REQ_INSERT: begin
                if (req_len != '0) begin
                  state_r <= (cnt_r == '0) ? ST_CHECK : ST_WALK;
                end
              end
              REQ_EXTRACT: begin
                if (x_hit) begin
                  xvalid_r <= 1'b1;
                  if (x_whole) begin
                    xbytes_r <= head_e_r - head_b_r;
                    bytes_r  <= bytes_r - (head_e_r - head_b_r);
                    ck_r     <= RCNT_W'(1);
                    state_r  <= ST_SHIFT;
                  end else begin
                    xbytes_r <= req_seq - head_b_r;
                    bytes_r  <= bytes_r - (req_seq - head_b_r);
                    head_b_r <= req_seq;
                  end
                end
              end
              REQ_INIT: begin
                next_r  <= req_seq;
                cnt_r   <= '0;
                bytes_r <= '0;
              end
              REQ_LEFT, REQ_RIGHT: begin
                edge_r  <= req_seq;
                state_r <= ST_EDGE;
              end
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_WALK: begin
          if (brk) begin
            stop_r  <= RCNT_W'(cur_r) + 1'b1;
            state_r <= ST_CHECK;
          end else begin
            if (mrg) begin
              if (sq_lt(rb, sb_r)) sb_r <= rb;
              if (sq_lt(se_r, re)) se_r <= re;
              gone_r[cur_r] <= 1'b1;
              merged_r      <= merged_r + 1'b1;
              lost_r        <= lost_r + (re - rb);
            end
            if (cur_r == '0) begin
              stop_r  <= '0;
              state_r <= ST_CHECK;
            end else begin
              cur_r <= cur_r - 1'b1;
            end
          end
        end
        ST_CHECK: begin
          // One more entry than the table holds drops the segment.
          if ((cnt_r - merged_r) == RCNT_W'(MAX_RANGES)) begin
            ovf_r   <= 1'b1;
            state_r <= ST_DONE;
          end else begin
            ck_r       <= '0;
            w_r        <= '0;
            new_done_r <= 1'b0;
            state_r    <= ST_COPY;
          end
        end
        ST_COPY: begin
          if (copy_new) begin
            new_done_r <= 1'b1;
            w_r        <= w_r + 1'b1;
            if (w_r == '0) begin
              head_b_r <= sb_r;
              head_e_r <= se_r;
            end
          end else if (ck_r == cnt_r) begin
            bank_r  <= !bank_r;
            cnt_r   <= w_r;
            bytes_r <= bytes_r - lost_r + (se_r - sb_r);
            state_r <= ST_DONE;
          end else begin
            if (!gone_r[ck_r[RIDX_W-1:0]]) begin
              w_r <= w_r + 1'b1;
              if (w_r == '0) begin
                head_b_r <= rb;
                head_e_r <= re;
              end
            end
            ck_r <= ck_p1;
          end
        end
        ST_SHIFT: begin
          if (ck_r == cnt_r) begin
            bank_r  <= !bank_r;
            cnt_r   <= cnt_m1;
            state_r <= ST_DONE;
          end else begin
            if (ck_r == RCNT_W'(1)) begin
              head_b_r <= rb;
              head_e_r <= re;
            end
            ck_r <= ck_p1;
          end
        end
        ST_EDGE: begin
          if (ck_r == cnt_r) begin
            state_r <= ST_DONE;
          end else if (req_r == REQ_LEFT && l_hit) begin
            edge_r  <= rb;
            state_r <= ST_DONE;
          end else if (req_r == REQ_RIGHT && r_hit) begin
            edge_r  <= re;
            state_r <= ST_DONE;
          end else begin
            ck_r <= ck_p1;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            next_r  <= next_adv;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RCNT_W'(MAX_RANGES))
    else $error("range table holds more entries than it has");

  a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (RCNT_W'(cur_r) < cnt_r))
    else $error("walk index beyond the held ranges");

  a_init_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && req_type == REQ_INIT) |=> (cnt_r == '0 && bytes_r == '0))
    else $error("init left ranges behind");

  a_copy_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY && wr_en) |-> (w_r < RCNT_W'(MAX_RANGES)))
    else $error("compaction writes past the table");

endmodule
`default_nettype wire

// ===== rtl/rrt_out_stage.sv =====
// Output register of the reassembly region tracker; frees the sequencer while a word waits.
// Depends on rrt_pkg.
`default_nettype none
module rrt_out_stage import rrt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     res_valid,
  output logic          res_ready,
  input  wire rrt_res_t res,
  output logic          out_valid,
  input  wire logic     out_ready,
  output rrt_res_t      out_data
);

  logic     valid_r;
  rrt_res_t data_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/reassembly_region_tracker_unit.sv =====
// Reassembly region tracker: keeps up to MAX_RANGES sorted received byte ranges in wrapping
// sequence space in two RAM banks and answers one result word per request word. An edge
// query reads the ranges in order until the enclosing one. A whole extract shifts the
// remaining ranges down into the other bank, and an insert runs a backward walk that reads
// one entry per cycle and stops at the first range wholly below the segment, then a copy of
// the entries not merged plus the new one into the other bank one per cycle. An insert
// dropped for a full table ends after the walk. A finished result leaves through an output
// register, so a new request can be taken while it waits.
// Depends on rrt_pkg, rrt_in_if, rrt_out_if, rrt_ram, rrt_ctrl and rrt_out_stage.
`default_nettype none
module reassembly_region_tracker_unit import rrt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [SEQ_W-1:0] cfg_wr_data,
  rrt_in_if.sink                in_chan,
  rrt_out_if.source             out_chan
);

  logic     res_valid, res_ready;
  rrt_res_t res, out_data;

  rrt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .req_valid(in_chan.valid), .req_ready(in_chan.ready),
    .req_type(in_chan.req_type), .req_seq(in_chan.seq_number),
    .req_len(in_chan.byte_count),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  rrt_out_stage u_out (
    .clk(clk), .rst_n(rst_n),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .out_valid(out_chan.valid), .out_ready(out_chan.ready), .out_data(out_data)
  );

  assign out_chan.next_expected   = out_data.next_expected;
  assign out_chan.first_held      = out_data.first_held;
  assign out_chan.extract_valid   = out_data.extract_valid;
  assign out_chan.extracted_bytes = out_data.extracted_bytes;
  assign out_chan.edge_seq        = out_data.edge_seq;
  assign out_chan.buffered_bytes  = out_data.buffered_bytes;
  assign out_chan.free_bytes      = out_data.free_bytes;
  assign out_chan.range_count     = out_data.range_count;
  assign out_chan.overflow        = out_data.overflow;

endmodule
`default_nettype wire
